// ===== rtl/lpcp_pkg.sv =====
// shared types and constants for the lidar point camera projector
`timescale 1ns / 1ps
`default_nettype none
package lpcp_pkg;

  typedef enum logic [1:0] {
    OP_PROJECT = 2'd0,
    OP_COEF    = 2'd1,
    OP_MAP     = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_FOCAL_X    = 3'd0,
    CFG_FOCAL_Y    = 3'd1,
    CFG_CENTRE_X   = 3'd2,
    CFG_CENTRE_Y   = 3'd3,
    CFG_IMAGE_COLS = 3'd4,
    CFG_IMAGE_ROWS = 3'd5
  } cfg_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [19:0]        write_index;
    logic [31:0]        write_value;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               hit;
    logic [7:0]         colour_0;
    logic [7:0]         colour_1;
    logic [7:0]         colour_2;
  } out_t;

  // divider geometry: numerator |cam|*2^16, denominator |z|, 31 quotient bits
  localparam int NUM_W = 58;
  localparam int DEN_W = 42;
  localparam int QB    = 31;
  localparam int SH_W  = DEN_W + QB;
  localparam logic [QB-1:0] RATIO_LIMIT = 31'h4000_0000;

  localparam logic [31:0] FOCAL_X_RST    = 32'd57984000;
  localparam logic [31:0] FOCAL_Y_RST    = 32'd57814000;
  localparam logic [31:0] CENTRE_X_RST   = 32'd41867000;
  localparam logic [31:0] CENTRE_Y_RST   = 32'd23991000;
  localparam logic [10:0] IMAGE_COLS_RST = 11'd1280;
  localparam logic [9:0]  IMAGE_ROWS_RST = 10'd720;

endpackage
`default_nettype wire

// ===== rtl/lpcp_divider.sv =====
// pipelined restoring divider with ratio saturation, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module lpcp_divider
  import lpcp_pkg::*;
(
  input  logic              clk_i,
  input  logic [QB:0]       ld_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic              neg_i,
  input  logic              ovf_i,
  output logic signed [31:0] t_o
);

  logic [NUM_W-1:0] rem_q [QB];
  logic [QB-1:0]    quo_q [QB];
  logic [DEN_W-1:0] den_q [QB];
  logic [QB-1:0]    neg_q;
  logic [QB-1:0]    ovf_q;
  logic signed [31:0] t_q;

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int B = QB - 1 - j;
    logic [NUM_W-1:0] rem_in;
    logic [QB-1:0]    quo_in;
    logic [DEN_W-1:0] den_in;
    logic             neg_in;
    logic             ovf_in;
    logic [SH_W-1:0]  trial;
    logic             take;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign neg_in = neg_i;
      assign ovf_in = ovf_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
      assign neg_in = neg_q[j-1];
      assign ovf_in = ovf_q[j-1];
    end

    assign trial = SH_W'(den_in) << B;
    assign take  = SH_W'(rem_in) >= trial;

    always_ff @(posedge clk_i) begin
      if (ld_i[j]) begin
        rem_q[j] <= take ? rem_in - trial[NUM_W-1:0] : rem_in;
        quo_q[j] <= take ? (quo_in | (QB'(1) << B)) : quo_in;
        den_q[j] <= den_in;
        neg_q[j] <= neg_in;
        ovf_q[j] <= ovf_in;
      end
    end
  end

  logic [QB-1:0] mag;
  logic [31:0]   mag_w;

  always_comb begin
    mag = (ovf_q[QB-1] || quo_q[QB-1] > RATIO_LIMIT) ? RATIO_LIMIT : quo_q[QB-1];
    mag_w = 32'(mag);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[QB]) begin
      t_q <= neg_q[QB-1] ? -$signed(mag_w) : $signed(mag_w);
    end
  end

  assign t_o = t_q;

endmodule
`default_nettype wire

// ===== rtl/lidar_point_camera_projection.sv =====
// lidar point to camera pixel projector top level
// throughput: one beat per cycle while the output is not stalled; depth comes from the 31-stage ratio divider
// stalls collapse bubbles stage by stage, input stalls only once every stage is full
// reset: config registers to defaults and the pipeline empties; coefficient
// table and remap memory are not cleared and hold nothing until written
`timescale 1ns / 1ps
`default_nettype none
module lidar_point_camera_projection
  import lpcp_pkg::*;
#(
  parameter int MAP_WIDTH  = 1280,
  parameter int MAP_HEIGHT = 720
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int MAP_CELLS = MAP_WIDTH * MAP_HEIGHT;
  localparam int ADDR_W    = $clog2(MAP_CELLS);
  localparam int CW        = $clog2(MAP_WIDTH);
  localparam int RW        = $clog2(MAP_HEIGHT);
  localparam int COEF_N    = 12;
  localparam int DIST_BITS = 9;
  localparam logic [65:0] DIST_K = 66'd42949672960000;

  localparam int ST_IN   = 0;
  localparam int ST_PROD = 1;
  localparam int ST_CAM  = 2;
  localparam int ST_PREP = 3;
  localparam int ST_DIV0 = 4;
  localparam int ST_T    = ST_DIV0 + QB;
  localparam int ST_MUL  = ST_T + 1;
  localparam int ST_RND  = ST_T + 2;
  localparam int ST_ADDR = ST_T + 3;
  localparam int ST_MEM  = ST_T + 4;
  localparam int ST_OUT  = ST_T + 5;
  localparam int NS      = ST_OUT + 1;

  typedef struct packed {
    logic [1:0]        op;
    logic [19:0]       widx;
    logic [31:0]       wval;
    logic [8:0][39:0]  prd;
    logic [2:0][23:0]  tr;
    logic [62:0]       x2;
    logic [62:0]       y2;
    logic              y_ok;
    logic [2:0][41:0]  cam;
    logic              zz;
    logic              sbig;
    logic [45:0]       s46;
    logic [61:0]       rhs;
    logic [8:0]        cur;
    logic [17:0]       cur_sq;
    logic [NUM_W-1:0]  num_x;
    logic [NUM_W-1:0]  num_y;
    logic [DEN_W-1:0]  den;
    logic              neg_x;
    logic              neg_y;
    logic              ovf_x;
    logic              ovf_y;
    logic [63:0]       prod_x;
    logic [63:0]       prod_y;
    logic [32:0]       col;
    logic [32:0]       row;
    logic              in_map;
    logic              wr_ok;
    logic [ADDR_W-1:0] addr;
  } pl_t;

  logic [31:0] focal_x_q, focal_y_q, centre_x_q, centre_y_q;
  logic [10:0] image_cols_q;
  logic [9:0]  image_rows_q;
  logic [31:0] coef_q [COEF_N];

  logic [NS-1:0] v_q;
  logic [NS-1:0] ld;
  in_t           s0_q;
  pl_t           pl_q [ST_PROD:ST_MEM];
  pl_t           nxt  [ST_PROD:ST_MEM];
  out_t          out_q, out_d;
  logic [31:0]   rdata_q;
  logic [31:0]   map_mem [MAP_CELLS];
  logic signed [31:0] tx, ty;

  function automatic logic [32:0] round_q32(input logic [63:0] acc);
    logic [32:0] ip;
    logic [31:0] fr;
    logic        up;
    ip = {acc[63], acc[63:32]};
    fr = acc[31:0];
    up = (fr > 32'h8000_0000) || (fr == 32'h8000_0000 && ip[0]);
    return ip + 33'(up);
  endfunction

  function automatic logic [23:0] ramp(input logic [7:0] d);
    logic [9:0] d4;
    logic [7:0] c0, c1, c2;
    d4 = {d, 2'b00};
    case (d[7:6])
      2'd0: begin
        c0 = 8'd255; c1 = 8'(10'd254 - d4); c2 = 8'd0;
      end
      2'd1: begin
        c0 = 8'(10'd510 - d4); c1 = 8'(d4 - 10'd254); c2 = 8'd0;
      end
      2'd2: begin
        c0 = 8'd0; c1 = 8'd255; c2 = 8'(d4 - 10'd510);
      end
      default: begin
        c0 = 8'd0; c1 = 8'(10'd1022 - d4); c2 = 8'd255;
      end
    endcase
    return {c0, c1, c2};
  endfunction

  // a stage loads when some stage at or after it is empty or the output drains
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      ld[k] = !out_stall_i || !(&(v_q | NS'((64'd1 << k) - 64'd1)));
    end
  end

  assign in_stall_o  = !ld[ST_IN];
  assign out_valid_o = v_q[ST_OUT];
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[ST_IN]) begin
        v_q[ST_IN] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q    <= FOCAL_X_RST;
      focal_y_q    <= FOCAL_Y_RST;
      centre_x_q   <= CENTRE_X_RST;
      centre_y_q   <= CENTRE_Y_RST;
      image_cols_q <= IMAGE_COLS_RST;
      image_rows_q <= IMAGE_ROWS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_e'(cfg_index_i))
        CFG_FOCAL_X:    focal_x_q    <= cfg_data_i;
        CFG_FOCAL_Y:    focal_y_q    <= cfg_data_i;
        CFG_CENTRE_X:   centre_x_q   <= cfg_data_i;
        CFG_CENTRE_Y:   centre_y_q   <= cfg_data_i;
        CFG_IMAGE_COLS: image_cols_q <= cfg_data_i[10:0];
        CFG_IMAGE_ROWS: image_rows_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // coefficients land at accept so every later beat sees them
  always_ff @(posedge clk_i) begin
    if (in_valid_i && ld[ST_IN] && in_data_i.opcode == OP_COEF &&
        in_data_i.write_index < 20'(COEF_N)) begin
      coef_q[in_data_i.write_index[3:0]] <= in_data_i.write_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_IN]) begin
      s0_q <= in_data_i;
    end
    for (int k = ST_PROD; k <= ST_MEM; k++) begin
      if (ld[k]) begin
        pl_q[k] <= nxt[k];
      end
    end
    if (ld[ST_OUT]) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    logic signed [31:0] pt [3];
    logic signed [63:0] m;
    logic signed [64:0] fm;
    logic [63:0]        s;
    logic [41:0]        ax, ay, az;
    logic [17:0]        tsq;
    logic [65:0]        tk;
    int                 b;

    pt[0] = s0_q.point_x;
    pt[1] = s0_q.point_y;
    pt[2] = s0_q.point_z;

    // products of points and rotation, translation and squares
    nxt[ST_PROD] = '0;
    nxt[ST_PROD].op   = s0_q.opcode;
    nxt[ST_PROD].widx = s0_q.write_index;
    nxt[ST_PROD].wval = s0_q.write_value;
    for (int c = 0; c < 9; c++) begin
      m = pt[c/3] * $signed(coef_q[c]);
      nxt[ST_PROD].prd[c] = m[63:24];
    end
    for (int i = 0; i < 3; i++) begin
      nxt[ST_PROD].tr[i] = coef_q[9+i][31:8];
    end
    m = pt[0] * pt[0];
    nxt[ST_PROD].x2 = m[62:0];
    m = pt[1] * pt[1];
    nxt[ST_PROD].y2 = m[62:0];
    nxt[ST_PROD].y_ok = (pt[1] > 32'sd0) && (pt[1] < 32'sd13107200);

    s = '0; ax = '0; ay = '0; az = '0; tsq = '0; tk = '0; b = 0; fm = '0;

    for (int k = ST_CAM; k <= ST_MEM; k++) begin
      nxt[k] = pl_q[k-1];
      if (k == ST_CAM) begin
        for (int i = 0; i < 3; i++) begin
          nxt[k].cam[i] = 42'($signed(pl_q[k-1].tr[i])) +
                          42'($signed(pl_q[k-1].prd[i])) +
                          42'($signed(pl_q[k-1].prd[3+i])) +
                          42'($signed(pl_q[k-1].prd[6+i]));
        end
        s = 64'(pl_q[k-1].x2) + 64'(pl_q[k-1].y2);
        nxt[k].sbig = |s[63:46];
        nxt[k].s46  = s[45:0];
      end
      if (k == ST_PREP) begin
        nxt[k].zz = (pl_q[k-1].cam[2] == '0);
        ax = pl_q[k-1].cam[0][41] ? -pl_q[k-1].cam[0] : pl_q[k-1].cam[0];
        ay = pl_q[k-1].cam[1][41] ? -pl_q[k-1].cam[1] : pl_q[k-1].cam[1];
        az = pl_q[k-1].cam[2][41] ? -pl_q[k-1].cam[2] : pl_q[k-1].cam[2];
        nxt[k].num_x = {ax, 16'd0};
        nxt[k].num_y = {ay, 16'd0};
        nxt[k].den   = az;
        nxt[k].neg_x = pl_q[k-1].cam[0][41] ^ pl_q[k-1].cam[2][41];
        nxt[k].neg_y = pl_q[k-1].cam[1][41] ^ pl_q[k-1].cam[2][41];
        // ratio at or above 2^31 saturates anyway
        nxt[k].ovf_x = SH_W'({ax, 16'd0}) >= {az, 31'd0};
        nxt[k].ovf_y = SH_W'({ay, 16'd0}) >= {az, 31'd0};
        nxt[k].rhs    = 62'(pl_q[k-1].s46) * 62'(65025);
        nxt[k].cur    = '0;
        nxt[k].cur_sq = '0;
      end
      // range root, one bit per stage alongside the divider
      if (k >= ST_DIV0 && k < ST_DIV0 + DIST_BITS) begin
        b = ST_DIV0 + DIST_BITS - 1 - k;
        tsq = pl_q[k-1].cur_sq + (18'(pl_q[k-1].cur) << (b + 1)) + (18'd1 << (2 * b));
        tk  = 66'(tsq) * DIST_K;
        if (tk <= 66'(pl_q[k-1].rhs)) begin
          nxt[k].cur    = pl_q[k-1].cur | 9'(1 << b);
          nxt[k].cur_sq = tsq;
        end
      end
      if (k == ST_MUL) begin
        fm = $signed({1'b0, focal_x_q}) * tx;
        nxt[k].prod_x = fm[63:0];
        fm = $signed({1'b0, focal_y_q}) * ty;
        nxt[k].prod_y = fm[63:0];
      end
      if (k == ST_RND) begin
        nxt[k].col = round_q32(pl_q[k-1].prod_x + {16'd0, centre_x_q, 16'd0});
        nxt[k].row = round_q32(pl_q[k-1].prod_y + {16'd0, centre_y_q, 16'd0});
      end
      if (k == ST_ADDR) begin
        nxt[k].in_map = (pl_q[k-1].op == OP_PROJECT) && !pl_q[k-1].zz &&
                        !pl_q[k-1].col[32] && pl_q[k-1].col[31:0] < 32'(MAP_WIDTH) &&
                        !pl_q[k-1].row[32] && pl_q[k-1].row[31:0] < 32'(MAP_HEIGHT);
        nxt[k].wr_ok  = (pl_q[k-1].op == OP_MAP) &&
                        (32'(pl_q[k-1].widx) < 32'(MAP_CELLS));
        if (pl_q[k-1].op == OP_MAP) begin
          nxt[k].addr = ADDR_W'(pl_q[k-1].widx);
        end else begin
          nxt[k].addr = ADDR_W'(32'(pl_q[k-1].row[RW-1:0]) * 32'(MAP_WIDTH) +
                                32'(pl_q[k-1].col[CW-1:0]));
        end
      end
    end
  end

  lpcp_divider u_div_x (
    .clk_i (clk_i),
    .ld_i  (ld[ST_T:ST_DIV0]),
    .num_i (pl_q[ST_PREP].num_x),
    .den_i (pl_q[ST_PREP].den),
    .neg_i (pl_q[ST_PREP].neg_x),
    .ovf_i (pl_q[ST_PREP].ovf_x),
    .t_o   (tx)
  );

  lpcp_divider u_div_y (
    .clk_i (clk_i),
    .ld_i  (ld[ST_T:ST_DIV0]),
    .num_i (pl_q[ST_PREP].num_y),
    .den_i (pl_q[ST_PREP].den),
    .neg_i (pl_q[ST_PREP].neg_y),
    .ovf_i (pl_q[ST_PREP].ovf_y),
    .t_o   (ty)
  );

  // remap memory: writes and reads happen in order at one stage
  always_ff @(posedge clk_i) begin
    if (ld[ST_MEM]) begin
      if (v_q[ST_ADDR] && pl_q[ST_ADDR].wr_ok) begin
        map_mem[pl_q[ST_ADDR].addr] <= pl_q[ST_ADDR].wval;
      end
      rdata_q <= map_mem[pl_q[ST_ADDR].addr];
    end
  end

  always_comb begin
    logic in_img;
    logic far;
    logic [23:0] rgb;
    out_d = '0;
    out_d.pixel_x = -16'sd1;
    out_d.pixel_y = -16'sd1;
    in_img = !rdata_q[15] && (16'(image_cols_q) > rdata_q[15:0]) &&
             !rdata_q[31] && (16'(image_rows_q) > rdata_q[31:16]);
    far = pl_q[ST_MEM].sbig || pl_q[ST_MEM].cur[8];
    rgb = ramp(pl_q[ST_MEM].cur[7:0]);
    if (pl_q[ST_MEM].in_map) begin
      out_d.pixel_x = $signed(rdata_q[15:0]);
      out_d.pixel_y = $signed(rdata_q[31:16]);
      if (in_img && pl_q[ST_MEM].y_ok) begin
        out_d.hit = 1'b1;
        if (!far) begin
          out_d.colour_0 = rgb[23:16];
          out_d.colour_1 = rgb[15:8];
          out_d.colour_2 = rgb[7:0];
        end
      end
    end
  end

endmodule
`default_nettype wire
